[design/double_ended_queue_core_assert.svh]
// assertion macros for the checker file
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// clocked check, quiet while reset is asserted
`define DEQ_CHECK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deque check failed");

// clocked check that also holds during reset
`define DEQ_CHECK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("deque check failed during reset");

`endif

[design/deq_pkg.sv]
package deq_pkg;

    typedef logic [2:0] req_code_t;
    typedef logic [1:0] status_t;

    // request codes, anything above REQ_NONE behaves as no operation
    localparam req_code_t REQ_PUSH_FRONT = 3'd0;
    localparam req_code_t REQ_PUSH_BACK  = 3'd1;
    localparam req_code_t REQ_POP_FRONT  = 3'd2;
    localparam req_code_t REQ_POP_BACK   = 3'd3;
    localparam req_code_t REQ_NONE       = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

[design/deq_ram.sv]
module deq_ram #(
    parameter int DEPTH = 256,
    parameter int WORD_BITS = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/double_ended_queue_core.sv]
// double-ended queue of DEPTH words of WORD_BITS bits, held in a ring in one
// synchronous single-port-write / single-port-read memory. each request beat on
// the input (push front, push back, pop front, pop back, none) yields exactly one
// result beat: status, popped word, word count, and the front and back words
// after the request. a push while full returns full and a pop while empty returns
// empty, both leaving the queue untouched; codes above none act as none. the
// front and back words live in registers beside the memory, so a push only writes
// the memory and a pop only needs to fetch the new end word. a request goes from
// idle to the out state, which waits while an untaken result is held, and then
// into the output register; a pop leaving two or more words first passes the read
// state, taking in the memory's registered read of the new end word. one request
// is in flight at a time; the next input beat is taken as soon as the result sits
// in the output register, even if the consumer has not yet taken it. no clearing
// pass after reset: unwritten memory entries are never read.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WORD_BITS = 32,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           req_type,
    input  logic [WORD_BITS-1:0] item_value,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [WORD_BITS-1:0] popped_value,
    output logic [CNT_W-1:0]     entry_total,
    output logic [WORD_BITS-1:0] front_value,
    output logic [WORD_BITS-1:0] back_value
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [PTR_W-1:0]     front_pos_reg;
    logic [PTR_W-1:0]     back_pos_reg;
    // cached end words, kept equal to the memory slots at front/back position
    logic [WORD_BITS-1:0] front_word_reg;
    logic [WORD_BITS-1:0] back_word_reg;
    // result of the request in flight
    status_t              status_reg;
    logic [WORD_BITS-1:0] popped_reg;
    logic                 fetch_front_reg;
    // output register
    logic                 out_valid_reg;
    status_t              status_out_reg;
    logic [WORD_BITS-1:0] popped_out_reg;
    logic [CNT_W-1:0]     total_out_reg;
    logic [WORD_BITS-1:0] front_out_reg;
    logic [WORD_BITS-1:0] back_out_reg;

    logic                 accept;
    logic                 out_free;
    logic                 load_out;
    logic                 is_push;
    logic                 is_pop;
    logic                 q_empty;
    logic                 q_full;
    logic                 do_push;
    logic                 do_pop;
    logic [PTR_W-1:0]     front_dn;
    logic [PTR_W-1:0]     front_up;
    logic [PTR_W-1:0]     back_dn;
    logic [PTR_W-1:0]     back_up;
    logic [PTR_W-1:0]     wr_slot;
    logic                 need_fetch;
    logic [PTR_W-1:0]     rd_slot;
    logic [WORD_BITS-1:0] rd_word;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    // the finished result moves into the output register
    assign load_out = (state_reg == S_OUT) && out_free;

    assign is_push = (req_type == REQ_PUSH_FRONT) || (req_type == REQ_PUSH_BACK);
    assign is_pop  = (req_type == REQ_POP_FRONT) || (req_type == REQ_POP_BACK);
    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg >= FULL_COUNT);
    assign do_push = accept && is_push && !q_full;
    assign do_pop  = accept && is_pop && !q_empty;

    // ring steps, wrapping modulo DEPTH
    assign front_dn = (front_pos_reg == '0) ? LAST_SLOT : front_pos_reg - 1'b1;
    assign front_up = (front_pos_reg == LAST_SLOT) ? '0 : front_pos_reg + 1'b1;
    assign back_dn  = (back_pos_reg == '0) ? LAST_SLOT : back_pos_reg - 1'b1;
    assign back_up  = (back_pos_reg == LAST_SLOT) ? '0 : back_pos_reg + 1'b1;

    // first word into an empty queue lands on the front slot for either side
    always_comb
    begin
        priority if (q_empty)
        begin
            wr_slot = front_pos_reg;
        end
        else if (req_type == REQ_PUSH_FRONT)
        begin
            wr_slot = front_dn;
        end
        else
        begin
            wr_slot = back_up;
        end
    end

    // a pop that leaves two or more words has to fetch the new end word
    assign need_fetch = do_pop && (count_reg > CNT_W'(2));
    assign rd_slot    = (req_type == REQ_POP_FRONT) ? front_up : back_dn;

    deq_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (wr_slot),
        .wr_data (item_value),
        .rd_en   (need_fetch),
        .rd_addr (rd_slot),
        .rd_data (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            front_pos_reg   <= '0;
            back_pos_reg    <= '0;
            front_word_reg  <= '0;
            back_word_reg   <= '0;
            status_reg      <= ST_OK;
            popped_reg      <= '0;
            fetch_front_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            status_out_reg  <= ST_OK;
            popped_out_reg  <= '0;
            total_out_reg   <= '0;
            front_out_reg   <= '0;
            back_out_reg    <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg      <= (is_push && q_full)  ? ST_FULL
                                         : (is_pop && q_empty)  ? ST_EMPTY
                                         : ST_OK;
                        popped_reg      <= !do_pop ? '0
                                         : (req_type == REQ_POP_FRONT) ? front_word_reg
                                         : back_word_reg;
                        fetch_front_reg <= (req_type == REQ_POP_FRONT);
                        state_reg       <= need_fetch ? S_READ : S_OUT;

                        if (do_push)
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (q_empty)
                            begin
                                back_pos_reg   <= front_pos_reg;
                                front_word_reg <= item_value;
                                back_word_reg  <= item_value;
                            end
                            else if (req_type == REQ_PUSH_FRONT)
                            begin
                                front_pos_reg  <= front_dn;
                                front_word_reg <= item_value;
                            end
                            else
                            begin
                                back_pos_reg  <= back_up;
                                back_word_reg <= item_value;
                            end
                        end

                        if (do_pop)
                        begin
                            count_reg <= count_reg - 1'b1;
                            if (req_type == REQ_POP_FRONT)
                            begin
                                front_pos_reg <= front_up;
                                // two words held: the back word becomes the front
                                if (count_reg == CNT_W'(2))
                                begin
                                    front_word_reg <= back_word_reg;
                                end
                            end
                            else
                            begin
                                back_pos_reg <= back_dn;
                                if (count_reg == CNT_W'(2))
                                begin
                                    back_word_reg <= front_word_reg;
                                end
                            end
                        end
                    end
                end

                S_READ:
                begin
                    if (fetch_front_reg)
                    begin
                        front_word_reg <= rd_word;
                    end
                    else
                    begin
                        back_word_reg <= rd_word;
                    end
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        status_out_reg <= status_reg;
                        popped_out_reg <= popped_reg;
                        total_out_reg  <= count_reg;
                        front_out_reg  <= q_empty ? '0 : front_word_reg;
                        back_out_reg   <= q_empty ? '0 : back_word_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_out_reg;
    assign popped_value = popped_out_reg;
    assign entry_total  = total_out_reg;
    assign front_value  = front_out_reg;
    assign back_value   = back_out_reg;

endmodule

[design/deq_checker.sv]
`include "double_ended_queue_core_assert.svh"

module deq_assert_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WORD_BITS = 32,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [1:0]           status,
    input logic [WORD_BITS-1:0] popped_value,
    input logic [CNT_W-1:0]     entry_total,
    input logic [WORD_BITS-1:0] front_value,
    input logic [WORD_BITS-1:0] back_value
);

    // a rejected push only happens at capacity
    `DEQ_CHECK(a_full_at_cap, out_valid && (status == ST_FULL) |-> entry_total == CNT_W'(DEPTH))

    // a pop that found the queue empty removes nothing
    `DEQ_CHECK(a_empty_pop,
        out_valid && (status == ST_EMPTY) |-> (entry_total == '0) && (popped_value == '0))

    // an empty queue shows zero end words
    `DEQ_CHECK(a_empty_ends,
        out_valid && (entry_total == '0) |-> (front_value == '0) && (back_value == '0))

    // a single word is both the front and the back
    `DEQ_CHECK(a_single_word, out_valid && (entry_total == CNT_W'(1)) |-> front_value == back_value)

    // a stalled result beat holds
    `DEQ_CHECK(a_out_hold,
        out_valid && !out_ready |=> out_valid && $stable(entry_total) && $stable(status))

endmodule

bind double_ended_queue_core deq_assert_checker #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
) u_deq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .popped_value (popped_value),
    .entry_total  (entry_total),
    .front_value  (front_value),
    .back_value   (back_value)
);

[tb/deq_checker.sv]
`timescale 1ns / 1ps

// watches both channels of the deque, keeps a shadow copy of its contents and
// compares every result beat with the oldest predicted one
module deq_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WORD_BITS = 32,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [2:0]           req_type,
    input  logic [WORD_BITS-1:0] item_value,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           status,
    input  logic [WORD_BITS-1:0] popped_value,
    input  logic [CNT_W-1:0]     entry_total,
    input  logic [WORD_BITS-1:0] front_value,
    input  logic [WORD_BITS-1:0] back_value,
    output int                   mismatches,
    output int                   outstanding,
    output int                   pushes_done,
    output int                   pops_done,
    output int                   full_rejects,
    output int                   empty_rejects,
    output int                   peak_total
);

    typedef struct packed {
        status_t              st;
        logic [WORD_BITS-1:0] popped;
        logic [CNT_W-1:0]     total;
        logic [WORD_BITS-1:0] front;
        logic [WORD_BITS-1:0] back;
    } deq_result_t;

    logic [WORD_BITS-1:0] shadow_words [DEPTH];
    logic [PTR_W-1:0]     head_slot;
    logic [PTR_W-1:0]     tail_slot;
    logic [CNT_W-1:0]     shadow_total;
    deq_result_t          awaited_results [$];

    assign outstanding = awaited_results.size();

    // applies one request to the shadow deque and returns the result it yields
    function automatic deq_result_t apply_request(input logic [2:0] code,
                                                  input logic [WORD_BITS-1:0] word);
        deq_result_t res;
        logic        at_front;
        res = '0;
        res.st = ST_OK;
        at_front = (code == REQ_PUSH_FRONT) || (code == REQ_POP_FRONT);
        if (code == REQ_PUSH_FRONT || code == REQ_PUSH_BACK) begin
            if (shadow_total == CNT_W'(DEPTH)) begin
                res.st = ST_FULL;
                full_rejects++;
            end else begin
                // first word of an empty deque lands on the front slot
                if (shadow_total == '0)
                    tail_slot = head_slot;
                else if (at_front)
                    head_slot = head_slot - 1'b1;
                else
                    tail_slot = tail_slot + 1'b1;
                shadow_words[at_front ? head_slot : tail_slot] = word;
                shadow_total = shadow_total + 1'b1;
                pushes_done++;
            end
        end else if (code == REQ_POP_FRONT || code == REQ_POP_BACK) begin
            if (shadow_total == '0) begin
                res.st = ST_EMPTY;
                empty_rejects++;
            end else begin
                if (at_front) begin
                    res.popped = shadow_words[head_slot];
                    head_slot = head_slot + 1'b1;
                end else begin
                    res.popped = shadow_words[tail_slot];
                    tail_slot = tail_slot - 1'b1;
                end
                shadow_total = shadow_total - 1'b1;
                pops_done++;
            end
        end
        res.total = shadow_total;
        if (shadow_total != '0) begin
            res.front = shadow_words[head_slot];
            res.back  = shadow_words[tail_slot];
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic [WORD_BITS-1:0] want,
                               input logic [WORD_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        deq_result_t want;
        if (!rst_n) begin
            head_slot     = '0;
            tail_slot     = '0;
            shadow_total  = '0;
            mismatches    = 0;
            pushes_done   = 0;
            pops_done     = 0;
            full_rejects  = 0;
            empty_rejects = 0;
            peak_total    = 0;
            awaited_results.delete();
        end else begin
            // results are older than any request taken at the same edge
            if (out_valid && out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with none expected, status %0h total %0d",
                             $time, status, entry_total);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", WORD_BITS'(want.st), WORD_BITS'(status));
                    check_field("popped_value", want.popped, popped_value);
                    check_field("entry_total", WORD_BITS'(want.total),
                                WORD_BITS'(entry_total));
                    check_field("front_value", want.front, front_value);
                    check_field("back_value", want.back, back_value);
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(apply_request(req_type, item_value));
            if (int'(shadow_total) > peak_total)
                peak_total = int'(shadow_total);
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import deq_pkg::*;

    localparam int DEPTH       = 256;
    localparam int WORD_BITS   = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    // longest legal quiet stretch is the forced receiver hold-off
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [2:0]           req_type;
    logic [WORD_BITS-1:0] item_value;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           status;
    logic [WORD_BITS-1:0] popped_value;
    logic [CNT_W-1:0]     entry_total;
    logic [WORD_BITS-1:0] front_value;
    logic [WORD_BITS-1:0] back_value;

    int mismatches;
    int outstanding;
    int pushes_done;
    int pops_done;
    int full_rejects;
    int empty_rejects;
    int peak_total;

    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   quiet_cycles       = 0;
    int   hold_len           = 0;
    logic hold_toggle        = 1'b0;

    double_ended_queue_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .item_value   (item_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .entry_total  (entry_total),
        .front_value  (front_value),
        .back_value   (back_value)
    );

    deq_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // any accepted beat on either side resets the stall counter
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        logic seen_toggle;
        int   hold_left;
        seen_toggle = 1'b0;
        hold_left   = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left   = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else
                out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_beat(input logic [2:0] code, input logic [WORD_BITS-1:0] word);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= code;
        item_value <= word;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // sender pauses until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [WORD_BITS-1:0] pick_word();
        int roll;
        roll = $urandom_range(15);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        return $urandom;
    endfunction

    // push_pct and pop_pct bias the mix; the rest are no-ops and unused codes
    task automatic run_mix(input int beats, input int push_pct, input int pop_pct);
        int          roll;
        logic [2:0]  code;
        for (int i = 0; i < beats; i++) begin
            roll = $urandom_range(99);
            if (roll < push_pct)
                code = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            else if (roll < push_pct + pop_pct)
                code = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
            else
                code = 3'($urandom_range(7, 4));
            send_beat(code, pick_word());
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_NONE;
        item_value = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, no-ops and unused codes, pushes into empty
        // from both ends, then a short mixed fill and full drain
        send_beat(REQ_POP_FRONT, 32'h1234_5678);
        send_beat(REQ_POP_BACK, '1);
        send_beat(REQ_NONE, '1);
        send_beat(3'd5, 32'h0000_0001);
        send_beat(3'd6, 32'h8000_0000);
        send_beat(3'd7, '1);
        send_beat(REQ_PUSH_FRONT, '1);
        send_beat(REQ_POP_BACK, '0);
        send_beat(REQ_PUSH_BACK, '0);
        send_beat(REQ_PUSH_FRONT, 32'hA5A5_A5A5);
        send_beat(REQ_PUSH_BACK, 32'h5A5A_5A5A);
        send_beat(REQ_PUSH_FRONT, 32'h0000_0001);
        send_beat(REQ_PUSH_BACK, 32'h8000_0000);
        send_beat(REQ_POP_FRONT, '0);
        send_beat(REQ_POP_BACK, '0);
        send_beat(REQ_POP_FRONT, '0);
        send_beat(REQ_POP_BACK, '0);
        send_beat(REQ_POP_FRONT, '0);
        send_beat(REQ_POP_BACK, '1);
        send_beat(REQ_NONE, 32'hDEAD_BEEF);
        drain_results();

        // no idling: fill past full with the receiver held off at the start,
        // then drain past empty
        hold_len = HOLD_CYCLES;
        hold_toggle <= ~hold_toggle;
        run_mix(300, 95, 3);
        run_mix(300, 3, 95);
        drain_results();

        // sender mostly idle, balanced traffic
        sender_idle_pct = 81;
        run_mix(300, 45, 45);
        drain_results();

        // receiver mostly stalled, another fill and drain
        sender_idle_pct    = 0;
        receiver_stall_pct = 81;
        run_mix(300, 95, 3);
        run_mix(300, 3, 95);
        drain_results();

        // light idling on both sides
        sender_idle_pct    = 24;
        receiver_stall_pct = 24;
        run_mix(300, 45, 45);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d pushes and %0d pops, %0d pushes refused as full, %0d pops as empty",
                 pushes_done, pops_done, full_rejects, empty_rejects);
        $display("deque reached %0d of %0d words under four idle and stall mixes",
                 peak_total, DEPTH);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
